// File: hw/rtl/tfnb_pkg.sv
// ---------------------------------------------------------------------------
// Triangle face normal and bounding box: shared package
// Payload types, controller states, and the command and status groups
// that join the controller to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package tfnb_pkg;

    localparam int COORD_W  = 32;
    localparam int DIFF_W   = 33;
    localparam int PROD_W   = 66;
    localparam int CROSS_W  = 67;
    localparam int MAG_W    = 66;
    localparam int NORM_W   = 30;
    localparam int SUM_W    = 62;
    localparam int SUM2_W   = 66;
    localparam int QUO_W    = 15;
    localparam int NRM_OUT_W = 16;
    localparam int DVD_W    = 65;
    localparam int REM_W    = 66;
    localparam int STEP_W   = 7;
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = 32;

    localparam logic [STEP_W-1:0] NORMAL_DIV_STEPS = STEP_W'(QUO_W);
    localparam logic [STEP_W-1:0] SCALE_DIV_STEPS  = STEP_W'(DVD_W);

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by_coord;
        logic signed [31:0] bz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic               last_triangle;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic        [31:0] mesh_scale;
        logic               end_of_mesh;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BOX,
        ST_CROSS,
        ST_CROSS_END,
        ST_MAG,
        ST_NORM,
        ST_SQ,
        ST_SQ_END,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SCL_CHK,
        ST_SCL_MUL,
        ST_SCL_END,
        ST_SCL_TEST,
        ST_SCL_DIV,
        ST_SCL_DIV_WAIT,
        ST_SCL_SQRT,
        ST_SCL_SQRT_WAIT,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_U1V2,
        MUL_U2V1,
        MUL_U2V0,
        MUL_U0V2,
        MUL_U0V1,
        MUL_U1V0,
        MUL_M0,
        MUL_M1,
        MUL_M2,
        MUL_D0,
        MUL_D1,
        MUL_D2
    } mul_sel_t;

    typedef enum logic {
        SQRT_SUM,
        SQRT_QUOT
    } sqrt_src_t;

    typedef enum logic {
        DIV_NORMAL,
        DIV_SCALE
    } div_mode_t;

    typedef struct packed {
        logic      load;
        logic      box_en;
        logic [1:0] box_sel;
        mul_sel_t  mul_sel;
        logic      mag_load;
        logic      norm_step;
        logic      sqrt_start;
        sqrt_src_t sqrt_src;
        logic      div_start;
        div_mode_t div_mode;
        logic [1:0] div_idx;
        logic      q_store;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
        logic use_fixed;
        logic norm_zero;
        logic norm_ok;
        logic s2_small;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/tfnb_div.sv
// ---------------------------------------------------------------------------
// Triangle face normal and bounding box: restoring divider
// Produces one quotient bit per cycle from a preloaded partial remainder
// and a dividend shifted in MSB first.
// ---------------------------------------------------------------------------
`default_nettype none

module tfnb_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tfnb_pkg::REM_W-1:0]  rem_init,
    input  wire logic [tfnb_pkg::DVD_W-1:0]  dividend,
    input  wire logic [tfnb_pkg::REM_W-1:0]  divisor,
    input  wire logic [tfnb_pkg::STEP_W-1:0] steps,
    output logic      [tfnb_pkg::DVD_W-1:0]  quotient,
    output logic                             done
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [tfnb_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [tfnb_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [tfnb_pkg::DVD_W-1:0]  dvd_reg, dvd_next;
    logic [tfnb_pkg::REM_W-1:0]  div_reg, div_next;
    logic [tfnb_pkg::DVD_W-1:0]  quo_reg, quo_next;
    logic [tfnb_pkg::REM_W:0]    rem_sh;
    logic [tfnb_pkg::REM_W:0]    rem_diff;
    logic                        ge;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[tfnb_pkg::DVD_W-1]};
        rem_diff = rem_sh - {1'b0, div_reg};
        ge       = rem_sh >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = rem_init;
            dvd_next  = dividend;
            div_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_diff[tfnb_pkg::REM_W-1:0] : rem_sh[tfnb_pkg::REM_W-1:0];
            dvd_next = {dvd_reg[tfnb_pkg::DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[tfnb_pkg::DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tfnb_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tfnb_isqrt.sv
// ---------------------------------------------------------------------------
// Triangle face normal and bounding box: integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tfnb_isqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tfnb_pkg::RAD_W-1:0] radicand,
    output logic      [tfnb_pkg::ROOT_W-1:0] root,
    output logic                            done
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [tfnb_pkg::RAD_W-1:0] x_reg, x_next;
    logic [tfnb_pkg::RAD_W-1:0] r_reg, r_next;
    logic [tfnb_pkg::RAD_W-1:0] bit_reg, bit_next;
    logic [tfnb_pkg::RAD_W-1:0] trial;

    always_comb
    begin
        trial     = r_reg + bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            x_next    = radicand;
            r_next    = '0;
            bit_next  = {2'b01, {(tfnb_pkg::RAD_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign root = r_reg[tfnb_pkg::ROOT_W-1:0];
    assign done = done_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tfnb_dp.sv
// ---------------------------------------------------------------------------
// Triangle face normal and bounding box: datapath
// Input capture, box update, shared multiplier with accumulators,
// normalization shifter, divider, square root and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tfnb_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tfnb_pkg::in_item_t    in_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [31:0]           cfg_wr_data,
    input  wire tfnb_pkg::ctrl_cmd_t   cmd,
    output tfnb_pkg::dp_status_t       status,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output tfnb_pkg::out_item_t        out_data
);

    tfnb_pkg::in_item_t          in_reg;
    logic [31:0]                 fixed_scale_reg;
    logic                        box_empty_reg;
    logic signed [31:0]          min_reg [3];
    logic signed [31:0]          max_reg [3];
    logic signed [tfnb_pkg::DIFF_W-1:0]  u_reg [3];
    logic signed [tfnb_pkg::DIFF_W-1:0]  v_reg [3];
    logic signed [tfnb_pkg::PROD_W-1:0]  prod_reg;
    tfnb_pkg::mul_sel_t          prod_sel_reg;
    logic signed [tfnb_pkg::CROSS_W-1:0] w_reg [3];
    logic [tfnb_pkg::MAG_W-1:0]  mag_reg [3];
    logic                        neg_reg [3];
    logic [tfnb_pkg::SUM_W-1:0]  s_reg;
    logic [tfnb_pkg::SUM2_W-1:0] s2_reg;
    logic [tfnb_pkg::QUO_W-1:0]  q_reg [3];
    logic                        out_valid_reg;
    tfnb_pkg::out_item_t         out_reg;

    logic signed [31:0]          vtx [3];
    logic [31:0]                 span [3];
    logic signed [tfnb_pkg::DIFF_W-1:0] op_a, op_b;
    logic signed [tfnb_pkg::CROSS_W-1:0] prod_ext;
    logic [tfnb_pkg::MAG_W-1:0]  comb;
    logic [44:0]                 num;
    logic [tfnb_pkg::NORM_W-1:0] m_sel;
    logic [tfnb_pkg::REM_W-1:0]  d_rem, d_dvs;
    logic [tfnb_pkg::DVD_W-1:0]  d_dvd;
    logic [tfnb_pkg::STEP_W-1:0] d_steps;
    logic [tfnb_pkg::DVD_W-1:0]  quotient;
    logic                        div_done;
    logic [tfnb_pkg::RAD_W-1:0]  radicand;
    logic [tfnb_pkg::ROOT_W-1:0] root;
    logic                        sqrt_done;
    logic signed [15:0]          nrm [3];
    logic [31:0]                 scale;
    logic                        norm_zero;
    logic                        s2_small;

    function automatic logic signed [tfnb_pkg::DIFF_W-1:0] DIFF_EXT(logic signed [31:0] c);
        return {c[31], c};
    endfunction

    always_comb
    begin
        case (cmd.box_sel)
            2'd0:
            begin
                vtx[0] = in_reg.ax;
                vtx[1] = in_reg.ay;
                vtx[2] = in_reg.az;
            end
            2'd1:
            begin
                vtx[0] = in_reg.bx;
                vtx[1] = in_reg.by_coord;
                vtx[2] = in_reg.bz;
            end
            default:
            begin
                vtx[0] = in_reg.cx;
                vtx[1] = in_reg.cy;
                vtx[2] = in_reg.cz;
            end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            span[i] = 32'(max_reg[i] - min_reg[i]);
        end
    end

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_sel)
            tfnb_pkg::MUL_U1V2: begin op_a = u_reg[1]; op_b = v_reg[2]; end
            tfnb_pkg::MUL_U2V1: begin op_a = u_reg[2]; op_b = v_reg[1]; end
            tfnb_pkg::MUL_U2V0: begin op_a = u_reg[2]; op_b = v_reg[0]; end
            tfnb_pkg::MUL_U0V2: begin op_a = u_reg[0]; op_b = v_reg[2]; end
            tfnb_pkg::MUL_U0V1: begin op_a = u_reg[0]; op_b = v_reg[1]; end
            tfnb_pkg::MUL_U1V0: begin op_a = u_reg[1]; op_b = v_reg[0]; end
            tfnb_pkg::MUL_M0:
            begin
                op_a = {3'b000, mag_reg[0][tfnb_pkg::NORM_W-1:0]};
                op_b = op_a;
            end
            tfnb_pkg::MUL_M1:
            begin
                op_a = {3'b000, mag_reg[1][tfnb_pkg::NORM_W-1:0]};
                op_b = op_a;
            end
            tfnb_pkg::MUL_M2:
            begin
                op_a = {3'b000, mag_reg[2][tfnb_pkg::NORM_W-1:0]};
                op_b = op_a;
            end
            tfnb_pkg::MUL_D0: begin op_a = {1'b0, span[0]}; op_b = op_a; end
            tfnb_pkg::MUL_D1: begin op_a = {1'b0, span[1]}; op_b = op_a; end
            tfnb_pkg::MUL_D2: begin op_a = {1'b0, span[2]}; op_b = op_a; end
            default: begin op_a = '0; op_b = '0; end
        endcase
        prod_ext = tfnb_pkg::CROSS_W'(prod_reg);
    end

    always_comb
    begin
        comb      = mag_reg[0] | mag_reg[1] | mag_reg[2];
        norm_zero = comb == '0;
        s2_small  = s2_reg <= tfnb_pkg::SUM2_W'(1);
        m_sel     = mag_reg[cmd.div_idx][tfnb_pkg::NORM_W-1:0];
        num       = {1'b0, m_sel, 14'b0} + {15'b0, root[30:1]};
        if (cmd.div_mode == tfnb_pkg::DIV_NORMAL)
        begin
            d_rem   = {36'b0, num[44:15]};
            d_dvd   = {num[14:0], 50'b0};
            d_dvs   = {35'b0, root[30:0]};
            d_steps = tfnb_pkg::NORMAL_DIV_STEPS;
        end
        else
        begin
            d_rem   = '0;
            d_dvd   = {1'b1, 64'b0};
            d_dvs   = s2_reg;
            d_steps = tfnb_pkg::SCALE_DIV_STEPS;
        end
        if (cmd.sqrt_src == tfnb_pkg::SQRT_SUM)
        begin
            radicand = {2'b00, s_reg};
        end
        else
        begin
            radicand = quotient[tfnb_pkg::RAD_W-1:0];
        end
        for (int i = 0; i < 3; i++)
        begin
            if (norm_zero)
            begin
                nrm[i] = '0;
            end
            else if (neg_reg[i])
            begin
                nrm[i] = -{1'b0, q_reg[i]};
            end
            else
            begin
                nrm[i] = {1'b0, q_reg[i]};
            end
        end
        if (!in_reg.last_triangle)
        begin
            scale = '0;
        end
        else if (fixed_scale_reg != '0)
        begin
            scale = fixed_scale_reg;
        end
        else if (s2_small)
        begin
            scale = 32'hFFFF_FFFF;
        end
        else
        begin
            scale = root;
        end
    end

    tfnb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .rem_init (d_rem),
        .dividend (d_dvd),
        .divisor  (d_dvs),
        .steps    (d_steps),
        .quotient (quotient),
        .done     (div_done)
    );

    tfnb_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (radicand),
        .root     (root),
        .done     (sqrt_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_scale_reg <= '0;
            box_empty_reg   <= 1'b1;
            prod_sel_reg    <= tfnb_pkg::MUL_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fixed_scale_reg <= cfg_wr_data;
            end
            if (cmd.box_en)
            begin
                box_empty_reg <= 1'b0;
            end
            else if (cmd.out_load && in_reg.last_triangle)
            begin
                box_empty_reg <= 1'b1;
            end
            prod_sel_reg <= cmd.mul_sel;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg   <= in_data;
            u_reg[0] <= DIFF_EXT(in_data.bx) - DIFF_EXT(in_data.ax);
            u_reg[1] <= DIFF_EXT(in_data.by_coord) - DIFF_EXT(in_data.ay);
            u_reg[2] <= DIFF_EXT(in_data.bz) - DIFF_EXT(in_data.az);
            v_reg[0] <= DIFF_EXT(in_data.cx) - DIFF_EXT(in_data.bx);
            v_reg[1] <= DIFF_EXT(in_data.cy) - DIFF_EXT(in_data.by_coord);
            v_reg[2] <= DIFF_EXT(in_data.cz) - DIFF_EXT(in_data.bz);
            s_reg    <= '0;
            s2_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else
        begin
            case (prod_sel_reg)
                tfnb_pkg::MUL_U1V2: w_reg[0] <= w_reg[0] + prod_ext;
                tfnb_pkg::MUL_U2V1: w_reg[0] <= w_reg[0] - prod_ext;
                tfnb_pkg::MUL_U2V0: w_reg[1] <= w_reg[1] + prod_ext;
                tfnb_pkg::MUL_U0V2: w_reg[1] <= w_reg[1] - prod_ext;
                tfnb_pkg::MUL_U0V1: w_reg[2] <= w_reg[2] + prod_ext;
                tfnb_pkg::MUL_U1V0: w_reg[2] <= w_reg[2] - prod_ext;
                tfnb_pkg::MUL_M0, tfnb_pkg::MUL_M1, tfnb_pkg::MUL_M2:
                    s_reg <= s_reg + prod_reg[tfnb_pkg::SUM_W-1:0];
                tfnb_pkg::MUL_D0, tfnb_pkg::MUL_D1, tfnb_pkg::MUL_D2:
                    s2_reg <= s2_reg + {2'b00, prod_reg[63:0]};
                default: ;
            endcase
        end
        prod_reg <= op_a * op_b;
        if (cmd.box_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (box_empty_reg && cmd.box_sel == 2'd0)
                begin
                    min_reg[i] <= vtx[i];
                    max_reg[i] <= vtx[i];
                end
                else
                begin
                    if (vtx[i] < min_reg[i])
                    begin
                        min_reg[i] <= vtx[i];
                    end
                    if (vtx[i] > max_reg[i])
                    begin
                        max_reg[i] <= vtx[i];
                    end
                end
            end
        end
        if (cmd.mag_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= w_reg[i][tfnb_pkg::CROSS_W-1];
                mag_reg[i] <= w_reg[i][tfnb_pkg::CROSS_W-1]
                    ? tfnb_pkg::MAG_W'(-w_reg[i]) : tfnb_pkg::MAG_W'(w_reg[i]);
            end
        end
        else if (cmd.norm_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (comb[65:34] != '0)
                begin
                    mag_reg[i] <= mag_reg[i] >> 4;
                end
                else if (comb[65:30] != '0)
                begin
                    mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (comb[65:25] == '0)
                begin
                    mag_reg[i] <= mag_reg[i] << 4;
                end
                else
                begin
                    mag_reg[i] <= mag_reg[i] << 1;
                end
            end
        end
        if (cmd.q_store)
        begin
            q_reg[cmd.div_idx] <= quotient[tfnb_pkg::QUO_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_reg.normal_x    <= nrm[0];
            out_reg.normal_y    <= nrm[1];
            out_reg.normal_z    <= nrm[2];
            out_reg.box_min_x   <= min_reg[0];
            out_reg.box_min_y   <= min_reg[1];
            out_reg.box_min_z   <= min_reg[2];
            out_reg.box_max_x   <= max_reg[0];
            out_reg.box_max_y   <= max_reg[1];
            out_reg.box_max_z   <= max_reg[2];
            out_reg.mesh_scale  <= scale;
            out_reg.end_of_mesh <= in_reg.last_triangle;
        end
    end

    assign status.last      = in_reg.last_triangle;
    assign status.use_fixed = fixed_scale_reg != '0;
    assign status.norm_zero = norm_zero;
    assign status.norm_ok   = (comb[65:30] == '0) && comb[29];
    assign status.s2_small  = s2_small;
    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tfnb_ctrl.sv
// ---------------------------------------------------------------------------
// Triangle face normal and bounding box: controller
// Sequences box update, cross product, normalization, square roots and
// divisions for one triangle at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module tfnb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tfnb_pkg::dp_status_t status,
    output tfnb_pkg::ctrl_cmd_t       cmd
);

    tfnb_pkg::ctrl_state_t state_reg, state_next;
    logic [2:0]            cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfnb_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            tfnb_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = tfnb_pkg::ST_BOX;
                    cnt_next   = '0;
                end
            tfnb_pkg::ST_BOX:
                if (cnt_reg == 3'd2)
                begin
                    state_next = tfnb_pkg::ST_CROSS;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            tfnb_pkg::ST_CROSS:
                if (cnt_reg == 3'd5)
                begin
                    state_next = tfnb_pkg::ST_CROSS_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            tfnb_pkg::ST_CROSS_END: state_next = tfnb_pkg::ST_MAG;
            tfnb_pkg::ST_MAG:       state_next = tfnb_pkg::ST_NORM;
            tfnb_pkg::ST_NORM:
                if (status.norm_zero)
                begin
                    state_next = tfnb_pkg::ST_SCL_CHK;
                end
                else if (status.norm_ok)
                begin
                    state_next = tfnb_pkg::ST_SQ;
                    cnt_next   = '0;
                end
            tfnb_pkg::ST_SQ:
                if (cnt_reg == 3'd2)
                begin
                    state_next = tfnb_pkg::ST_SQ_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            tfnb_pkg::ST_SQ_END:     state_next = tfnb_pkg::ST_SQRT_START;
            tfnb_pkg::ST_SQRT_START: state_next = tfnb_pkg::ST_SQRT_WAIT;
            tfnb_pkg::ST_SQRT_WAIT:
                if (status.sqrt_done)
                begin
                    state_next = tfnb_pkg::ST_DIV_START;
                    cnt_next   = '0;
                end
            tfnb_pkg::ST_DIV_START: state_next = tfnb_pkg::ST_DIV_WAIT;
            tfnb_pkg::ST_DIV_WAIT:
                if (status.div_done)
                begin
                    if (cnt_reg == 3'd2)
                    begin
                        state_next = tfnb_pkg::ST_SCL_CHK;
                    end
                    else
                    begin
                        state_next = tfnb_pkg::ST_DIV_START;
                        cnt_next   = cnt_reg + 3'd1;
                    end
                end
            tfnb_pkg::ST_SCL_CHK:
                if (!status.last || status.use_fixed)
                begin
                    state_next = tfnb_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = tfnb_pkg::ST_SCL_MUL;
                    cnt_next   = '0;
                end
            tfnb_pkg::ST_SCL_MUL:
                if (cnt_reg == 3'd2)
                begin
                    state_next = tfnb_pkg::ST_SCL_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            tfnb_pkg::ST_SCL_END: state_next = tfnb_pkg::ST_SCL_TEST;
            tfnb_pkg::ST_SCL_TEST:
                state_next = status.s2_small ? tfnb_pkg::ST_FINISH : tfnb_pkg::ST_SCL_DIV;
            tfnb_pkg::ST_SCL_DIV: state_next = tfnb_pkg::ST_SCL_DIV_WAIT;
            tfnb_pkg::ST_SCL_DIV_WAIT:
                if (status.div_done)
                begin
                    state_next = tfnb_pkg::ST_SCL_SQRT;
                end
            tfnb_pkg::ST_SCL_SQRT: state_next = tfnb_pkg::ST_SCL_SQRT_WAIT;
            tfnb_pkg::ST_SCL_SQRT_WAIT:
                if (status.sqrt_done)
                begin
                    state_next = tfnb_pkg::ST_FINISH;
                end
            tfnb_pkg::ST_FINISH:
                if (status.out_free)
                begin
                    state_next = tfnb_pkg::ST_IDLE;
                end
            default: state_next = tfnb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = tfnb_pkg::MUL_NONE;
        cmd.sqrt_src = tfnb_pkg::SQRT_SUM;
        cmd.div_mode = tfnb_pkg::DIV_NORMAL;
        cmd.div_idx  = cnt_reg[1:0];
        cmd.box_sel  = cnt_reg[1:0];
        in_ready     = 1'b0;
        case (state_reg)
            tfnb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tfnb_pkg::ST_BOX: cmd.box_en = 1'b1;
            tfnb_pkg::ST_CROSS:
                case (cnt_reg)
                    3'd0:    cmd.mul_sel = tfnb_pkg::MUL_U1V2;
                    3'd1:    cmd.mul_sel = tfnb_pkg::MUL_U2V1;
                    3'd2:    cmd.mul_sel = tfnb_pkg::MUL_U2V0;
                    3'd3:    cmd.mul_sel = tfnb_pkg::MUL_U0V2;
                    3'd4:    cmd.mul_sel = tfnb_pkg::MUL_U0V1;
                    default: cmd.mul_sel = tfnb_pkg::MUL_U1V0;
                endcase
            tfnb_pkg::ST_MAG: cmd.mag_load = 1'b1;
            tfnb_pkg::ST_NORM: cmd.norm_step = !status.norm_zero && !status.norm_ok;
            tfnb_pkg::ST_SQ:
                case (cnt_reg)
                    3'd0:    cmd.mul_sel = tfnb_pkg::MUL_M0;
                    3'd1:    cmd.mul_sel = tfnb_pkg::MUL_M1;
                    default: cmd.mul_sel = tfnb_pkg::MUL_M2;
                endcase
            tfnb_pkg::ST_SQRT_START: cmd.sqrt_start = 1'b1;
            tfnb_pkg::ST_DIV_START:  cmd.div_start = 1'b1;
            tfnb_pkg::ST_DIV_WAIT:   cmd.q_store = status.div_done;
            tfnb_pkg::ST_SCL_MUL:
                case (cnt_reg)
                    3'd0:    cmd.mul_sel = tfnb_pkg::MUL_D0;
                    3'd1:    cmd.mul_sel = tfnb_pkg::MUL_D1;
                    default: cmd.mul_sel = tfnb_pkg::MUL_D2;
                endcase
            tfnb_pkg::ST_SCL_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = tfnb_pkg::DIV_SCALE;
            end
            tfnb_pkg::ST_SCL_DIV_WAIT: cmd.div_mode = tfnb_pkg::DIV_SCALE;
            tfnb_pkg::ST_SCL_SQRT:
            begin
                cmd.sqrt_start = 1'b1;
                cmd.sqrt_src   = tfnb_pkg::SQRT_QUOT;
            end
            tfnb_pkg::ST_SCL_SQRT_WAIT: cmd.sqrt_src = tfnb_pkg::SQRT_QUOT;
            tfnb_pkg::ST_FINISH: cmd.out_load = status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/triangle_face_normal_bbox_top.sv
// ---------------------------------------------------------------------------
// Triangle face normal and bounding box: top level
// Unit face normal in Q2.14 and running bounding box per triangle, with
// the mesh scale on the last triangle of a mesh.
//
//   Channel   Signals                            Transfer when
//   input     in_valid, in_ready, in_data        in_valid && in_ready
//   output    out_valid, out_ready, out_data     out_valid && out_ready
//   config    cfg_wr_en, cfg_wr_data             cfg_wr_en
//
// One triangle is in work at a time, through the 32-step square root and
// three 15-step quotient divisions on the shared iterative units, plus up to
// 12 normalization shifts; a degenerate triangle skips the square root and
// divisions. The last triangle with a derived scale adds a 65-step division
// and a second square root, or only span squares and a test when the box
// diagonal is at most one unit. Reset clears control state, the fixed scale
// and the box-empty flag. A stalled output holds the finished triangle in the
// output register while the next triangle is already accepted and computed.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal_bbox_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tfnb_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tfnb_pkg::out_item_t      out_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [31:0]         cfg_wr_data
);

    tfnb_pkg::ctrl_cmd_t  cmd;
    tfnb_pkg::dp_status_t status;

    tfnb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tfnb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a triangle is in work");

    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("output valid raised without a result load");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.div_start && cmd.sqrt_start))
        else $error("divider and square root started together");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result load would overwrite an unsent transfer");

endmodule

`default_nettype wire
